@@ rtl/core/matrix_keypad_scanner_unit_assert.svh @@
// ---------------------------------------------------------------------------
// Keypad scanner assertion macros
// Concurrent checks sampled on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef MATRIX_KEYPAD_SCANNER_UNIT_ASSERT_SVH
`define MATRIX_KEYPAD_SCANNER_UNIT_ASSERT_SVH

// same-cycle implication
`define KSS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("keypad scanner check failed");

// next-cycle implication
`define KSS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("keypad scanner check failed");

`endif

@@ rtl/core/kss_pkg.sv @@
// ---------------------------------------------------------------------------
// kss_pkg
// Types, constants and lookup functions of the 4x4 keypad scanner.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kss_pkg;

  localparam int COL_W     = 4;
  localparam int ROW_W     = 2;
  localparam int CODE_W    = 8;
  localparam int KEY_IDX_W = 4;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 8;

  localparam logic [CODE_W-1:0] NO_KEY     = 8'hFF;
  localparam logic [KEY_IDX_W-1:0] STAR_IDX = 4'hC;
  localparam logic [KEY_IDX_W-1:0] HASH_IDX = 4'hE;
  localparam logic [ROW_W-1:0] LAST_ROW    = 2'd3;
  localparam logic [ROW_W-1:0] FIRST_ROW   = 2'd0;

  localparam logic [CFG_IDX_W-1:0] CFG_REPORT_ON_PRESS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEX_MODE        = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STAR_CHAR       = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HASH_CHAR       = 8'd3;

  localparam logic [CODE_W-1:0] STAR_RESET = 8'h2A;
  localparam logic [CODE_W-1:0] HASH_RESET = 8'h23;

  localparam logic [CODE_W-1:0] HEX_TABLE [16] = '{
    8'h01, 8'h02, 8'h03, 8'h0A,
    8'h04, 8'h05, 8'h06, 8'h0B,
    8'h07, 8'h08, 8'h09, 8'h0C,
    8'h0F, 8'h00, 8'h0E, 8'h0D
  };

  localparam logic [CODE_W-1:0] CHAR_TABLE [16] = '{
    8'h31, 8'h32, 8'h33, 8'h41,
    8'h34, 8'h35, 8'h36, 8'h42,
    8'h37, 8'h38, 8'h39, 8'h43,
    8'h2A, 8'h30, 8'h23, 8'h44
  };

  typedef struct packed {
    logic              report_on_press;
    logic              hex_mode;
    logic [CODE_W-1:0] star_char;
    logic [CODE_W-1:0] hash_char;
  } cfg_t;

  function automatic logic [COL_W-1:0] walk_zero(logic [ROW_W-1:0] pos);
    return ~(4'b1000 >> pos);
  endfunction

  function automatic logic [CODE_W-1:0] key_lookup(logic [KEY_IDX_W-1:0] idx, cfg_t cfg);
    logic [CODE_W-1:0] code;
    if (cfg.hex_mode) begin
      code = HEX_TABLE[idx];
    end else if (idx == STAR_IDX) begin
      code = cfg.star_char;
    end else if (idx == HASH_IDX) begin
      code = cfg.hash_char;
    end else begin
      code = CHAR_TABLE[idx];
    end
    return code;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/kss_in_if.sv @@
// ---------------------------------------------------------------------------
// kss_in_if
// Column sample request channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface kss_in_if;
  import kss_pkg::*;

  logic             valid;
  logic             ready;
  logic [COL_W-1:0] column_lines;

  modport source (output valid, output column_lines, input ready);
  modport sink   (input valid, input column_lines, output ready);
endinterface

`default_nettype wire

@@ rtl/core/kss_out_if.sv @@
// ---------------------------------------------------------------------------
// kss_out_if
// Scan result channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface kss_out_if;
  import kss_pkg::*;

  logic              valid;
  logic              ready;
  logic [COL_W-1:0]  row_drive;
  logic              scan_done;
  logic              key_valid;
  logic [CODE_W-1:0] key_code;

  modport source (output valid, output row_drive, output scan_done, output key_valid,
                  output key_code, input ready);
  modport sink   (input valid, input row_drive, input scan_done, input key_valid,
                  input key_code, output ready);
endinterface

`default_nettype wire

@@ rtl/core/kss_cfg_if.sv @@
// ---------------------------------------------------------------------------
// kss_cfg_if
// Register write channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface kss_cfg_if;
  import kss_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/kss_cfg_regs.sv @@
// ---------------------------------------------------------------------------
// kss_cfg_regs
// Configuration register file; writes to unknown indexes are dropped.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kss_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  kss_cfg_if.sink       cfg_ch,
  output kss_pkg::cfg_t cfg
);
  import kss_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_REPORT_ON_PRESS: cfg_nxt.report_on_press = cfg_ch.data[0];
        CFG_HEX_MODE:        cfg_nxt.hex_mode        = cfg_ch.data[0];
        CFG_STAR_CHAR:       cfg_nxt.star_char       = cfg_ch.data;
        CFG_HASH_CHAR:       cfg_nxt.hash_char       = cfg_ch.data;
        default:             cfg_nxt                 = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.report_on_press <= 1'b1;
      cfg_r.hex_mode        <= 1'b0;
      cfg_r.star_char       <= STAR_RESET;
      cfg_r.hash_char       <= HASH_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/kss_scan_core.sv @@
// ---------------------------------------------------------------------------
// kss_scan_core
// Input register, row decode and key decision, result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "matrix_keypad_scanner_unit_assert.svh"

module kss_scan_core (
  input  logic          clk,
  input  logic          rst_n,
  input  kss_pkg::cfg_t cfg,
  kss_in_if.sink        in_ch,
  kss_out_if.source     out_ch
);
  import kss_pkg::*;

  logic              s1_valid_r;
  logic              s1_valid_nxt;
  logic [COL_W-1:0]  s1_cols_r;
  logic              s1_fire;
  logic              in_fire;

  logic [ROW_W-1:0]  row_idx_r;
  logic [ROW_W-1:0]  row_idx_nxt;
  logic [CODE_W-1:0] found_key_r;
  logic [CODE_W-1:0] found_key_nxt;
  logic [CODE_W-1:0] saved_key_r;
  logic [CODE_W-1:0] saved_key_nxt;

  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [COL_W-1:0]  row_drive_r;
  logic              scan_done_r;
  logic              key_valid_r;
  logic [CODE_W-1:0] key_code_r;

  logic              hit;
  logic [ROW_W-1:0]  hit_col;
  logic [CODE_W-1:0] key;
  logic [CODE_W-1:0] report;
  logic              done;

  assign s1_fire      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || s1_fire;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign s1_valid_nxt = in_fire || (s1_valid_r && !s1_fire);
  assign out_valid_nxt = s1_fire || (out_valid_r && !out_ch.ready);

  always_comb begin
    hit     = 1'b0;
    hit_col = '0;
    for (int c = 0; c < 4; c++) begin
      if (s1_cols_r == walk_zero(ROW_W'(c))) begin
        hit     = 1'b1;
        hit_col = ROW_W'(c);
      end
    end
  end

  always_comb begin
    done = (row_idx_r == LAST_ROW);
    key  = (row_idx_r == FIRST_ROW) ? NO_KEY : found_key_r;
    if (hit) begin
      key = key_lookup({row_idx_r, hit_col}, cfg);
    end
    report        = NO_KEY;
    saved_key_nxt = saved_key_r;
    found_key_nxt = key;
    if (done) begin
      found_key_nxt = NO_KEY;
      if (cfg.report_on_press && (saved_key_r != key)) begin
        saved_key_nxt = key;
        report        = key;
      end else if (key == NO_KEY) begin
        saved_key_nxt = NO_KEY;
        report        = saved_key_r;
      end else begin
        saved_key_nxt = key;
      end
    end
    row_idx_nxt = row_idx_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      row_idx_r   <= '0;
      found_key_r <= NO_KEY;
      saved_key_r <= NO_KEY;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_fire) begin
        row_idx_r   <= row_idx_nxt;
        found_key_r <= found_key_nxt;
        saved_key_r <= saved_key_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cols_r <= in_ch.column_lines;
    end
    if (s1_fire) begin
      row_drive_r <= walk_zero(row_idx_nxt);
      scan_done_r <= done;
      key_valid_r <= done && (report != NO_KEY);
      key_code_r  <= report;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.row_drive = row_drive_r;
  assign out_ch.scan_done = scan_done_r;
  assign out_ch.key_valid = key_valid_r;
  assign out_ch.key_code  = key_code_r;

  `KSS_ASSERT_NOW(a_key_code_mid_scan, out_valid_r && !scan_done_r, key_code_r == NO_KEY)
  `KSS_ASSERT_NOW(a_key_valid_code, out_valid_r, key_valid_r == (key_code_r != NO_KEY))
  `KSS_ASSERT_NOW(a_row_one_zero, out_valid_r, $countones(row_drive_r) == 3)
  `KSS_ASSERT_NEXT(a_row_wrap, s1_fire && done, row_idx_r == FIRST_ROW && found_key_r == NO_KEY)

endmodule

`default_nettype wire

@@ rtl/core/matrix_keypad_scanner_unit.sv @@
// ---------------------------------------------------------------------------
// matrix_keypad_scanner_unit
// 4x4 keypad scanner: one column sample request in, one scan result out.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch carries one column sample per request, taken for the row that the
//   previous result's row_drive selected (row one after reset).
//   out_ch returns one result per request: next row pattern, scan_done after
//   the fourth row, and the decided key code (255 and key_valid low for none).
//   cfg_ch writes report_on_press, hex_mode, star_char, hash_char by index;
//   it is always ready; the user must see that writes go in only while no
//   request is in flight, as the block does not enforce it.
// Throughput: one request per cycle while out_ch.ready holds; the input
//   register and the result register form a two-entry pipeline, so a
//   request is taken while a result waits.
// Reset: row counter to row one, found and saved keys to none, registers to
//   their defaults, both pipeline stages empty.
// Stall: a held result keeps its request in the input register; in_ch.ready
//   drops while both stages are full and the result is held.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module matrix_keypad_scanner_unit (
  input  logic      clk,
  input  logic      rst_n,
  kss_in_if.sink    in_ch,
  kss_out_if.source out_ch,
  kss_cfg_if.sink   cfg_ch
);
  import kss_pkg::*;

  cfg_t cfg;

  kss_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  kss_scan_core u_scan_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire
